FILE: rtl/core/qfs_pkg.sv
// Package: beat types, result kinds and character codes for the quoted field splitter.
`timescale 1ns / 1ps
package qfs_pkg;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  localparam int QFS_QDEPTH = 4;
  localparam int QFS_PTR_W  = $clog2(QFS_QDEPTH);
  localparam int QFS_CNT_W  = $clog2(QFS_QDEPTH + 1);

  typedef enum logic [2:0] {
    KIND_BEGIN      = 3'd0,
    KIND_CONT       = 3'd1,
    KIND_END        = 3'd2,
    KIND_EMPTY      = 3'd3,
    KIND_DONE       = 3'd4,
    KIND_ERR_BSLASH = 3'd5,
    KIND_ERR_QUOTE  = 3'd6
  } qfs_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_line;
  } qfs_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [7:0] field_count;
    logic       last_of_run;
  } qfs_out_t;

  // One queue entry: a result, and whether a done result follows it.
  typedef struct packed {
    logic       two;
    qfs_kind_t  kind;
    logic [7:0] data_byte;
    logic [7:0] count;
  } qfs_entry_t;

  typedef struct packed {
    logic       push;
    qfs_entry_t entry;
  } qfs_push_t;

endpackage

FILE: rtl/core/qfs_front.sv
// Front end: accepts input beats, tracks quoting state and classifies each byte.
`timescale 1ns / 1ps
module qfs_front import qfs_pkg::*; #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  qfs_in_t   in_data,
  input  logic      q_full,
  output qfs_push_t q_push
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  logic                   field_r, field_nxt;
  logic                   quote_r, quote_nxt;
  logic                   esc_r, esc_nxt;
  logic [COUNT_WIDTH-1:0] seen_r, seen_nxt;
  logic [COUNT_WIDTH-1:0] seen_after;
  logic [COUNT_WIDTH+7:0] seen_ext;
  logic [7:0]             shown;
  logic                   accept;
  logic                   term;
  logic                   blank;
  logic                   counted;
  logic                   push;
  logic                   two;
  qfs_kind_t              kind;
  logic [7:0]             data_byte;
  logic [7:0]             c;

  assign c        = in_data.in_byte;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign term     = in_data.end_of_line || (c == CHAR_NUL);
  assign blank    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));

  always_comb begin
    field_nxt = field_r;
    quote_nxt = quote_r;
    esc_nxt   = esc_r;
    counted   = 1'b0;
    push      = 1'b0;
    two       = 1'b0;
    kind      = KIND_DONE;
    data_byte = 8'h00;
    if (term) begin
      push      = 1'b1;
      field_nxt = 1'b0;
      quote_nxt = 1'b0;
      esc_nxt   = 1'b0;
      if (esc_r) begin
        kind = KIND_ERR_BSLASH;
      end else if (quote_r) begin
        kind = KIND_ERR_QUOTE;
      end else if (field_r) begin
        kind = KIND_END;
        two  = 1'b1;
      end else begin
        kind = KIND_DONE;
      end
    end else if (esc_r || !((blank && !quote_r) || (c == CHAR_QUOTE) ||
                            (c == CHAR_BSLASH && quote_r))) begin
      esc_nxt   = 1'b0;
      push      = 1'b1;
      data_byte = c;
      if (!field_r) begin
        field_nxt = 1'b1;
        counted   = 1'b1;
        kind      = KIND_BEGIN;
      end else begin
        kind = KIND_CONT;
      end
    end else if (blank && !quote_r) begin
      if (field_r) begin
        field_nxt = 1'b0;
        push      = 1'b1;
        kind      = KIND_END;
      end
    end else if (c == CHAR_QUOTE) begin
      if (quote_r) begin
        push      = 1'b1;
        field_nxt = 1'b0;
        quote_nxt = 1'b0;
        if (!field_r) begin
          counted = 1'b1;
          kind    = KIND_EMPTY;
        end else begin
          kind = KIND_END;
        end
      end else begin
        quote_nxt = 1'b1;
      end
    end else begin
      esc_nxt = 1'b1;
    end
  end

  always_comb begin
    seen_after = seen_r;
    if (counted && (seen_r != CountMax)) begin
      seen_after = seen_r + 1'b1;
    end
    seen_nxt = term ? '0 : seen_after;
    seen_ext = {8'h00, seen_after};
    shown    = (seen_ext > (COUNT_WIDTH + 8)'(255)) ? 8'hFF : seen_ext[7:0];
  end

  assign q_push.push            = accept && push;
  assign q_push.entry.two       = two;
  assign q_push.entry.kind      = kind;
  assign q_push.entry.data_byte = data_byte;
  assign q_push.entry.count     = shown;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= 1'b0;
      quote_r <= 1'b0;
      esc_r   <= 1'b0;
      seen_r  <= '0;
    end else if (accept) begin
      field_r <= field_nxt;
      quote_r <= quote_nxt;
      esc_r   <= esc_nxt;
      seen_r  <= seen_nxt;
    end
  end

  a_esc_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> quote_r)
    else $error("escape pending outside quotes");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && term) |=> (seen_r == '0) && !field_r && !quote_r && !esc_r)
    else $error("terminator left state behind");

endmodule

FILE: rtl/core/qfs_queue.sv
// Short queue of classified results between the front and back ends.
`timescale 1ns / 1ps
module qfs_queue import qfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  qfs_push_t  q_push,
  output logic       q_full,
  input  logic       pop,
  output logic       q_empty,
  output qfs_entry_t head
);

  qfs_entry_t             mem_r [QFS_QDEPTH];
  logic [QFS_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QFS_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == QFS_CNT_W'(QFS_QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push.push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !q_push.push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push.push && q_full && !pop))
    else $error("queue overflow");

endmodule

FILE: rtl/core/qfs_back.sv
// Back end: expands queue entries into result beats behind an output register.
`timescale 1ns / 1ps
module qfs_back import qfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  qfs_entry_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output qfs_out_t   out_data
);

  logic       out_valid_r, out_valid_nxt;
  qfs_out_t   out_data_r, out_data_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] pend_count_r, pend_count_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign pop       = slot_free && !pend_r && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    pend_nxt       = pend_r;
    pend_count_nxt = pend_count_r;
    if (slot_free) begin
      if (pend_r) begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.kind        = KIND_DONE;
        out_data_nxt.out_byte    = 8'h00;
        out_data_nxt.field_count = pend_count_r;
        out_data_nxt.last_of_run = 1'b1;
        pend_nxt                 = 1'b0;
      end else if (!q_empty) begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.kind        = head.kind;
        out_data_nxt.out_byte    = head.data_byte;
        out_data_nxt.field_count = head.count;
        out_data_nxt.last_of_run = !head.two;
        pend_nxt                 = head.two;
        pend_count_nxt           = head.count;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    pend_count_r <= pend_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  a_pend_shown: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r && !out_data_r.last_of_run &&
               (out_data_r.kind == KIND_END))
    else $error("pending done without a field end on the output");

  a_no_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !pop)
    else $error("queue popped while a done beat is pending");

endmodule

FILE: rtl/core/quoted_field_splitter.sv
// Top level: quoted command-line field splitter.
//
//   port group   dir   handshake            payload
//   in_*         in    in_valid/in_ready    qfs_in_t  (in_byte, end_of_line)
//   out_*        out   out_valid/out_ready  qfs_out_t (kind, out_byte, field_count, last_of_run)
//
// One input beat per cycle is accepted while the 4-entry queue has room.
// Each beat yields zero, one or two result beats; the output register sends one per cycle
// while out_ready is high, so a beat that yields two results holds the back end until both
// are sent. An accepted beat is written to the queue, then loaded into the output register.
// Synchronous active-low reset clears the quoting state, the count and the queue.
// in_ready drops only when the queue is full; out_ready stalls only the back end.
`timescale 1ns / 1ps
module quoted_field_splitter import qfs_pkg::*; #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  qfs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output qfs_out_t out_data
);

  qfs_push_t  q_push;
  logic       q_full;
  logic       q_empty;
  logic       pop;
  qfs_entry_t head;

  qfs_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push)
  );

  qfs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .pop    (pop),
    .q_empty(q_empty),
    .head   (head)
  );

  qfs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
